/* src/ttm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the tolerance template matcher.
// Depends on nothing; used by ttm_ctrl, ttm_datapath and tolerance_template_matcher.
package ttm_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int FLEX_W    = 8;
   localparam int AXIS_W    = 16;
   localparam int INDEX_W   = 4;
   localparam int ENTRIES_W = 5;
   localparam int WORD_W    = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [FLEX_W-1:0]    FLEX_TOL_RESET = 8'd10;
   localparam logic [AXIS_W-1:0]    AXIS_TOL_RESET = 16'd25;
   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET  = 5'd16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FLEX_TOL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_TOL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TOL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_TOL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES  = 3'd4;

   typedef struct packed {
      logic [FLEX_W-1:0]        flex;
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load_write;
      logic query_start;
      logic scan_issue;
      logic finish;
      logic found;
      logic publish;
      logic from_held;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic issue_done;
      logic cmp_valid;
      logic cmp_hit;
   } dp_status_type;

   function automatic logic [FLEX_W:0] abs_diff_flex(input logic [FLEX_W-1:0] a,
                                                     input logic [FLEX_W-1:0] b);
      logic [FLEX_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      return d[FLEX_W] ? (~d + {{FLEX_W{1'b0}}, 1'b1}) : d;
   endfunction

   function automatic logic [AXIS_W:0] abs_diff_axis(input logic [AXIS_W-1:0] a,
                                                     input logic [AXIS_W-1:0] b);
      logic [AXIS_W:0] d;
      d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
      return d[AXIS_W] ? (~d + {{AXIS_W{1'b0}}, 1'b1}) : d;
   endfunction

endpackage

/* src/ttm_datapath.sv */
`timescale 1ns / 1ps
// Datapath: template memory with per-entry valid bits, query reading, scan
// pointer, tolerance compare and result registers. Depends on ttm_pkg.
module ttm_datapath #(
   parameter int TABLE_DEPTH = ttm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ttm_pkg::ctrl_cmd_type          cmd,
   output ttm_pkg::dp_status_type         status,
   input  logic [ttm_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [ttm_pkg::FLEX_W-1:0]     req_flex_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_x_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_y_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_z_value,
   input  logic [ttm_pkg::FLEX_W-1:0]     flex_tol,
   input  logic [ttm_pkg::AXIS_W-1:0]     x_tol,
   input  logic [ttm_pkg::AXIS_W-1:0]     y_tol,
   input  logic [ttm_pkg::AXIS_W-1:0]     z_tol,
   input  logic [ttm_pkg::ENTRIES_W-1:0]  entries_in_use,
   output logic                           rsp_matched,
   output logic [ttm_pkg::WORD_W-1:0]     rsp_word_number
);
   import ttm_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   entry_type             mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] vld_ff;

   entry_type   query_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_in_range;

   entry_type     rd_entry_ff;
   logic          rd_vld_ff;
   logic          cmp_valid_ff;
   logic [AW-1:0] cmp_idx_ff;
   entry_type     seen;

   logic [FLEX_W:0] flex_d;
   logic [AXIS_W:0] x_d, y_d, z_d;
   logic            hit;

   logic              live_matched;
   logic [WORD_W-1:0] live_word;
   logic              held_matched_ff;
   logic [WORD_W-1:0] held_word_ff;
   logic              rsp_matched_ff;
   logic [WORD_W-1:0] rsp_word_ff;

   assign wr_in_range = (32'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr     = AW'(req_entry_index);
   assign rd_addr     = rd_ptr_ff[AW-1:0];

   always_comb begin
      if (32'(entries_in_use) > TABLE_DEPTH) begin
         count_in = CW'(TABLE_DEPTH);
      end else begin
         count_in = CW'(entries_in_use);
      end
   end

   // Template memory: written on load, read one entry per scan cycle
   always_ff @(posedge clock) begin
      if (cmd.load_write && wr_in_range) begin
         mem[wr_addr] <= '{flex: req_flex_value, x: req_x_value,
                           y: req_y_value, z: req_z_value};
      end
      if (cmd.scan_issue) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rd_ptr_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_write && wr_in_range) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.query_start) begin
            rd_ptr_ff <= '0;
         end else if (cmd.scan_issue) begin
            rd_ptr_ff <= rd_ptr_ff + CW'(1);
         end
         cmp_valid_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         query_ff <= '{flex: req_flex_value, x: req_x_value,
                       y: req_y_value, z: req_z_value};
         count_ff <= count_in;
      end
      if (cmd.scan_issue) begin
         rd_vld_ff  <= vld_ff[rd_addr];
         cmp_idx_ff <= rd_addr;
      end
   end

   // An entry never loaded reads as the cleared template
   assign seen = rd_vld_ff ? rd_entry_ff : '0;

   always_comb begin
      flex_d = abs_diff_flex(query_ff.flex, seen.flex);
      x_d    = abs_diff_axis(query_ff.x, seen.x);
      y_d    = abs_diff_axis(query_ff.y, seen.y);
      z_d    = abs_diff_axis(query_ff.z, seen.z);
      hit    = (flex_d <= {1'b0, flex_tol}) && (x_d <= {1'b0, x_tol}) &&
               (y_d <= {1'b0, y_tol}) && (z_d <= {1'b0, z_tol});
   end

   assign status.issue_done = (rd_ptr_ff == count_ff);
   assign status.cmp_valid  = cmp_valid_ff;
   assign status.cmp_hit    = hit;

   assign live_matched = cmd.found;
   assign live_word    = cmd.found ? WORD_W'({1'b0, cmp_idx_ff} + (AW + 1)'(1)) : '0;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         held_matched_ff <= live_matched;
         held_word_ff    <= live_word;
      end
      if (cmd.publish) begin
         rsp_matched_ff <= cmd.from_held ? held_matched_ff : live_matched;
         rsp_word_ff    <= cmd.from_held ? held_word_ff : live_word;
      end
   end

   assign rsp_matched     = rsp_matched_ff;
   assign rsp_word_number = rsp_word_ff;

endmodule

/* src/ttm_ctrl.sv */
`timescale 1ns / 1ps
// Controller: accepts words, sequences the template scan and owns the
// result valid. Depends on ttm_pkg.
module ttm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ttm_pkg::dp_status_type status,
   output ttm_pkg::ctrl_cmd_type  cmd
);
   import ttm_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;
   logic      done_hit;
   logic      done_miss;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      done_hit  = (state_ff == SCAN) && status.cmp_valid && status.cmp_hit;
      // no compare hit: nothing left in flight and every entry issued
      done_miss = (state_ff == SCAN) && status.issue_done && !status.cmp_valid;

      cmd.load_write  = accept && (req_command == CMD_LOAD);
      cmd.query_start = accept && (req_command == CMD_QUERY);
      cmd.scan_issue  = (state_ff == SCAN) && !status.issue_done;
      cmd.finish      = done_hit || done_miss;
      cmd.found       = done_hit;
      cmd.from_held   = (state_ff == REPORT);
      cmd.publish     = out_free && (cmd.finish || (state_ff == REPORT));

      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.query_start) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (cmd.finish) begin
               state_in = out_free ? IDLE : REPORT;
            end
         end
         REPORT: begin
            if (out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/tolerance_template_matcher.sv */
`timescale 1ns / 1ps
// Tolerance template matcher, top level: configuration registers, controller, datapath.
// Load word: written to the table on accept, no result. Query word: one template read per cycle;
// the scan stops at the first hit (word number index+1), a miss gives matched 0, word 0.
// The next word is taken once the result registers; a stalled output holds it in REPORT.
// Synchronous reset: tolerances 10/25/25/25, 16 entries in use, table reads all zero.
// Depends on ttm_pkg, ttm_ctrl and ttm_datapath.
module tolerance_template_matcher #(
   parameter int TABLE_DEPTH = ttm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [ttm_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [ttm_pkg::FLEX_W-1:0]        req_flex_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_x_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_y_value,
   input  logic signed [ttm_pkg::AXIS_W-1:0] req_z_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   output logic [ttm_pkg::WORD_W-1:0]        rsp_word_number,
   input  logic                              csr_wr_en,
   input  logic [ttm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttm_pkg::CSR_DAT_W-1:0]     csr_wr_data
);
   import ttm_pkg::*;

   logic [FLEX_W-1:0]    flex_tol_ff;
   logic [AXIS_W-1:0]    x_tol_ff;
   logic [AXIS_W-1:0]    y_tol_ff;
   logic [AXIS_W-1:0]    z_tol_ff;
   logic [ENTRIES_W-1:0] entries_ff;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         flex_tol_ff <= FLEX_TOL_RESET;
         x_tol_ff    <= AXIS_TOL_RESET;
         y_tol_ff    <= AXIS_TOL_RESET;
         z_tol_ff    <= AXIS_TOL_RESET;
         entries_ff  <= ENTRIES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FLEX_TOL: flex_tol_ff <= csr_wr_data[FLEX_W-1:0];
            CSR_X_TOL:    x_tol_ff    <= csr_wr_data[AXIS_W-1:0];
            CSR_Y_TOL:    y_tol_ff    <= csr_wr_data[AXIS_W-1:0];
            CSR_Z_TOL:    z_tol_ff    <= csr_wr_data[AXIS_W-1:0];
            CSR_ENTRIES:  entries_ff  <= csr_wr_data[ENTRIES_W-1:0];
            default: ;
         endcase
      end
   end

   ttm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   ttm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_flex_value  (req_flex_value),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .req_z_value     (req_z_value),
      .flex_tol        (flex_tol_ff),
      .x_tol           (x_tol_ff),
      .y_tol           (y_tol_ff),
      .z_tol           (z_tol_ff),
      .entries_in_use  (entries_ff),
      .rsp_matched     (rsp_matched),
      .rsp_word_number (rsp_word_number)
   );

endmodule
